// ----- hw/rtl/counting_semaphore_table_core_macros.svh -----
// ---------------------------------------------------------------------------
// Counting semaphore table assertion macros
// Concurrent assertion wrappers used by the semaphore table RTL.
// ---------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("semaphore table assertion failed");
`define CST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("semaphore table sequencing assertion failed");
`else
`define CST_ASSERT(label, prop)
`define CST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/cst_pkg.sv -----
// ---------------------------------------------------------------------------
// Counting semaphore table package
// Sizes, command and status codes, and the slot search function.
// ---------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SEMS       = 256;
  localparam int QUEUE_SLOTS    = 16;
  localparam int REQUESTER_BITS = 8;

  localparam int SEM_BITS     = $clog2(NUM_SEMS);
  localparam int CNT_BITS     = SEM_BITS + 1;
  localparam int CMP_W        = (CNT_BITS > 8) ? CNT_BITS : 8;
  localparam int SLOT_BITS    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int REQ_W        = (REQUESTER_BITS < 8) ? REQUESTER_BITS : 8;
  localparam int WAITER_DEPTH = NUM_SEMS << SLOT_BITS;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_POST   = 2'd1,
    CMD_WAIT   = 2'd2,
    CMD_TRY    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSEM    = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_NOTALLOC = 3'd3,
    ST_QFULL    = 3'd4
  } status_t;

  typedef logic [QUEUE_SLOTS-1:0] slot_vec_t;

  function automatic logic [SLOT_BITS-1:0] lowest_set(slot_vec_t v);
    logic [SLOT_BITS-1:0] idx;
    idx = '0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/counting_semaphore_table_core.sv -----
// ---------------------------------------------------------------------------
// Counting semaphore table core
// Semaphore table with per-semaphore wait queues, one request at a time.
// ---------------------------------------------------------------------------
// A request (cmd, requester, sem_index, init_value) is taken when req_valid
// is high and req_stall is low. Replies leave through one output register on
// the rsp channel; the receiver holds it with rsp_stall and the request side
// keeps accepting once the sequencer is idle again.
// Each request walks idle, read and execute: the count and queue rows sit in
// memories with registered reads, so the reply is loaded in the execute state
// once the receiver is not stalling, and the next request is taken only back
// in idle. A post that wakes a waiter reads the waiter identifier from memory
// and passes through the wake and acknowledge states, giving the grant first
// and the post acknowledgement second. A wait that parks its requester
// gives no reply. One 32-bit adder serves post, wait and trywait updates.
// Allocation uses a fill count, since semaphores are never freed. Each queue
// row has a valid bit in flip-flops, so reset clears the table at once and
// requests can be taken as soon as reset is released.
// While the receiver stalls, the sequencer holds in the state that has a
// reply to give and accepts no new request.
// ---------------------------------------------------------------------------
`include "counting_semaphore_table_core_macros.svh"

module counting_semaphore_table_core
  import cst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  requester,
  input  logic [7:0]  sem_index,
  input  logic [31:0] init_value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  dest_requester,
  output logic [1:0]  reply_kind,
  output logic [2:0]  status,
  output logic [8:0]  result_index,
  output logic        success,
  output logic        last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAKE,
    S_ACK
  } state_t;

  state_t state;

  cmd_t              cmd_q;
  logic [REQ_W-1:0]  req_q;
  logic [7:0]        sem_q;
  logic [31:0]       init_q;
  logic [CNT_BITS-1:0] alloc_count;

  logic [31:0]       counts_mem [NUM_SEMS];
  slot_vec_t         row_mem [NUM_SEMS];
  logic [REQ_W-1:0]  ids_mem [WAITER_DEPTH];
  logic [NUM_SEMS-1:0] row_valid;

  logic [31:0]       count_q;
  slot_vec_t         row_q;
  logic              rv_q;
  logic [REQ_W-1:0]  id_q;

  logic [CMP_W-1:0]    sem_ext;
  logic [SEM_BITS-1:0] sem_addr;
  logic                bad_idx;
  logic                not_alloc;
  logic                table_full;
  slot_vec_t           row_eff;
  logic [SLOT_BITS-1:0] waker_slot;
  logic [SLOT_BITS-1:0] free_slot;
  logic                cnt_zero;
  logic                cnt_max;
  logic [31:0]         addend;
  logic [31:0]         sum;
  logic                out_free;

  logic                cnt_we;
  logic [SEM_BITS-1:0] cnt_waddr;
  logic [31:0]         cnt_wdata;
  logic                row_we;
  slot_vec_t           row_wdata;
  logic                id_we;
  logic                alloc_inc;
  logic                emit;
  logic                go;
  state_t              exec_next;
  status_t             e_status;
  logic [8:0]          e_index;
  logic                e_success;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    sem_ext    = CMP_W'(sem_q);
    sem_addr   = sem_q[SEM_BITS-1:0];
    bad_idx    = sem_ext >= CMP_W'(NUM_SEMS);
    not_alloc  = sem_ext >= CMP_W'(alloc_count);
    table_full = alloc_count == CNT_BITS'(NUM_SEMS);
    row_eff    = rv_q ? row_q : '0;
    waker_slot = lowest_set(row_eff);
    free_slot  = lowest_set(~row_eff);
    cnt_zero   = count_q == '0;
    cnt_max    = &count_q;
    addend     = (cmd_q == CMD_POST) ? 32'd1 : '1;
    sum        = count_q + addend;
    out_free   = !rsp_valid || !rsp_stall;

    cnt_we    = 1'b0;
    cnt_waddr = sem_addr;
    cnt_wdata = sum;
    row_we    = 1'b0;
    row_wdata = row_eff;
    id_we     = 1'b0;
    alloc_inc = 1'b0;
    emit      = 1'b1;
    exec_next = S_IDLE;
    e_status  = ST_OK;
    e_index   = '0;
    e_success = 1'b0;

    if (cmd_q == CMD_CREATE) begin
      if (!table_full) begin
        cnt_we    = 1'b1;
        cnt_waddr = alloc_count[SEM_BITS-1:0];
        cnt_wdata = init_q;
        alloc_inc = 1'b1;
        e_index   = 9'(alloc_count);
      end else begin
        e_status = ST_NOSEM;
        e_index  = 9'(NUM_SEMS);
      end
    end else if (bad_idx) begin
      e_status = ST_BADIDX;
    end else if (not_alloc) begin
      e_status = ST_NOTALLOC;
    end else begin
      case (cmd_q)
        CMD_POST: begin
          if (cnt_zero && (|row_eff)) begin
            row_we    = 1'b1;
            row_wdata = row_eff ^ (slot_vec_t'(1) << waker_slot);
            emit      = 1'b0;
            exec_next = S_WAKE;
          end else begin
            cnt_we = !cnt_max;
          end
        end
        CMD_WAIT: begin
          if (!cnt_zero) begin
            cnt_we = 1'b1;
          end else if (|(~row_eff)) begin
            row_we    = 1'b1;
            row_wdata = row_eff ^ (slot_vec_t'(1) << free_slot);
            id_we     = 1'b1;
            emit      = 1'b0;
          end else begin
            e_status = ST_QFULL;
          end
        end
        CMD_TRY: begin
          if (!cnt_zero) begin
            cnt_we    = 1'b1;
            e_success = 1'b1;
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end

    go = (state == S_EXEC) && (out_free || !emit);
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cmd_q  <= cmd_t'(cmd);
      req_q  <= requester[REQ_W-1:0];
      sem_q  <= sem_index;
      init_q <= init_value;
    end
  end

  always_ff @(posedge clk) begin
    count_q <= counts_mem[sem_addr];
    if (go && cnt_we) begin
      counts_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    row_q <= row_mem[sem_addr];
    if (go && row_we) begin
      row_mem[sem_addr] <= row_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      id_q <= ids_mem[{sem_addr, waker_slot}];
    end
    if (go && id_we) begin
      ids_mem[{sem_addr, free_slot}] <= req_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rv_q      <= 1'b0;
    end else begin
      rv_q <= row_valid[sem_addr];
      if (go && row_we) begin
        row_valid[sem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      alloc_count <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            state <= exec_next;
            if (alloc_inc) begin
              alloc_count <= alloc_count + 1'b1;
            end
            if (emit) begin
              rsp_valid      <= 1'b1;
              dest_requester <= 8'(req_q);
              reply_kind     <= cmd_q;
              status         <= e_status;
              result_index   <= e_index;
              success        <= e_success;
              last           <= 1'b1;
            end
          end
        end
        S_WAKE: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            dest_requester <= 8'(id_q);
            reply_kind     <= CMD_WAIT;
            status         <= ST_OK;
            result_index   <= '0;
            success        <= 1'b0;
            last           <= 1'b0;
            state          <= S_ACK;
          end
        end
        S_ACK: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            dest_requester <= 8'(req_q);
            reply_kind     <= CMD_POST;
            status         <= ST_OK;
            result_index   <= '0;
            success        <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A pending wake grant is always followed by the post acknowledgement.
  `CST_ASSERT(a_grant_then_ack, (rsp_valid && !last) |-> (state == S_ACK))
  `CST_ASSERT(a_alloc_bound, alloc_count <= CNT_BITS'(NUM_SEMS))
  `CST_ASSERT_NEXT(a_accept_reads, req_valid && !req_stall, state == S_READ)
  `CST_ASSERT_NEXT(a_wake_reply, state == S_WAKE && out_free, rsp_valid && !last)

endmodule

// ----- bench/counting_semaphore_table_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Counting semaphore table core testbench
// Drives create, post, wait and trywait requests with random gaps and reply
// stalls. A behavioural copy of the semaphore table predicts every reply,
// and each reply taken from the block is checked field by field in order.
// ---------------------------------------------------------------------------
module counting_semaphore_table_core_tb;
  import cst_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    logic [7:0] dest;
    cmd_t       kind;
    status_t    code;
    logic [8:0] index;
    logic       granted;
    logic       is_last;
  } reply_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        req_valid  = 1'b0;
  logic        req_stall;
  logic [1:0]  cmd        = '0;
  logic [7:0]  requester  = '0;
  logic [7:0]  sem_index  = '0;
  logic [31:0] init_value = '0;
  logic        rsp_valid;
  logic        rsp_stall  = 1'b0;
  logic [7:0]  dest_requester;
  logic [1:0]  reply_kind;
  logic [2:0]  status;
  logic [8:0]  result_index;
  logic        success;
  logic        last;

  reply_t      expected_replies[$];
  logic [31:0] sem_count[NUM_SEMS];
  bit          waiter_busy[NUM_SEMS][QUEUE_SLOTS];
  logic [7:0]  waiter_id[NUM_SEMS][QUEUE_SLOTS];
  int          sems_created = 0;
  int          mismatches   = 0;
  int          idle_cycles  = 0;
  bit          steady_flow  = 1'b0;

  counting_semaphore_table_core DUT (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .requester      (requester),
    .sem_index      (sem_index),
    .init_value     (init_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .dest_requester (dest_requester),
    .reply_kind     (reply_kind),
    .status         (status),
    .result_index   (result_index),
    .success        (success),
    .last           (last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void apply_semaphore_request(cmd_t op, logic [7:0] who,
                                                  logic [7:0] sem, logic [31:0] init);
    reply_t r;
    reply_t grant;
    who = who & 8'((1 << REQUESTER_BITS) - 1);
    r = '{dest: who, kind: op, code: ST_OK, index: '0, granted: 1'b0, is_last: 1'b1};
    if (op == CMD_CREATE) begin
      if (sems_created < NUM_SEMS) begin
        sem_count[sems_created] = init;
        r.index = 9'(sems_created);
        sems_created++;
      end else begin
        r.code  = ST_NOSEM;
        r.index = 9'(NUM_SEMS);
      end
    end else if (int'(sem) >= NUM_SEMS) begin
      r.code = ST_BADIDX;
    end else if (int'(sem) >= sems_created) begin
      r.code = ST_NOTALLOC;
    end else begin
      case (op)
        CMD_POST: begin
          if (sem_count[sem] == 32'd0) begin
            for (int s = 0; s < QUEUE_SLOTS; s++) begin
              if (waiter_busy[sem][s]) begin
                waiter_busy[sem][s] = 1'b0;
                grant = '{dest: waiter_id[sem][s], kind: CMD_WAIT, code: ST_OK,
                          index: '0, granted: 1'b0, is_last: 1'b0};
                expected_replies.push_back(grant);
                expected_replies.push_back(r);
                return;
              end
            end
          end
          if (sem_count[sem] != 32'hFFFF_FFFF) begin
            sem_count[sem] = sem_count[sem] + 32'd1;
          end
        end
        CMD_WAIT: begin
          if (sem_count[sem] != 32'd0) begin
            sem_count[sem] = sem_count[sem] - 32'd1;
          end else begin
            for (int s = 0; s < QUEUE_SLOTS; s++) begin
              if (!waiter_busy[sem][s]) begin
                waiter_busy[sem][s] = 1'b1;
                waiter_id[sem][s]   = who;
                return;
              end
            end
            r.code = ST_QFULL;
          end
        end
        default: begin
          if (sem_count[sem] != 32'd0) begin
            sem_count[sem] = sem_count[sem] - 32'd1;
            r.granted = 1'b1;
          end
        end
      endcase
    end
    expected_replies.push_back(r);
  endfunction

  task automatic send_request(cmd_t op, logic [7:0] who, logic [7:0] sem, logic [31:0] init);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    cmd        <= op;
    requester  <= who;
    sem_index  <= sem;
    init_value <= init;
    do @(posedge clk); while (req_stall);
    apply_semaphore_request(op, who, sem, init);
  endtask

  function automatic logic [7:0] pick_semaphore();
    int roll;
    roll = $urandom_range(0, 99);
    if (sems_created == 0 || roll < 15) begin
      return 8'($urandom_range(0, 255));
    end
    if (roll < 30) begin
      return 8'($urandom_range(0, sems_created - 1));
    end
    return 8'($urandom_range(sems_created > 6 ? sems_created - 6 : 0, sems_created - 1));
  endfunction

  function automatic logic [31:0] pick_init();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 32'($urandom_range(0, 2));
    end else if (roll < 75) begin
      return 32'($urandom);
    end else if (roll < 90) begin
      return 32'hFFFF_FFFF - 32'($urandom_range(0, 1));
    end
    return 32'($urandom_range(0, 8));
  endfunction

  task automatic test_unallocated_access();
    send_request(CMD_POST, 8'h00, 8'h00, 32'h0000_0000);
    send_request(CMD_WAIT, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_create_extremes();
    send_request(CMD_CREATE, 8'hA5, 8'h5A, 32'h0000_0000);
    send_request(CMD_CREATE, 8'h5A, 8'hA5, 32'hFFFF_FFFF);
  endtask

  task automatic test_count_saturation();
    send_request(CMD_POST, 8'h01, 8'd1, 32'h0);
    send_request(CMD_TRY, 8'h02, 8'd1, 32'h0);
  endtask

  task automatic test_wait_queue();
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      send_request(CMD_WAIT, (i < 2) ? 8'h33 : 8'(i * 17), 8'd0, 32'($urandom));
    end
    send_request(CMD_WAIT, 8'hC3, 8'd0, 32'h0);
    send_request(CMD_POST, 8'h44, 8'd0, 32'h0);
    send_request(CMD_TRY, 8'h55, 8'd0, 32'h0);
  endtask

  task automatic test_random_traffic();
    int   roll;
    cmd_t op;
    for (int n = 0; n < 1925; n++) begin
      if (n % 100 == 0) begin
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        op = CMD_CREATE;
      end else if (roll < 45) begin
        op = CMD_POST;
      end else if (roll < 78) begin
        op = CMD_WAIT;
      end else begin
        op = CMD_TRY;
      end
      send_request(op, 8'($urandom), pick_semaphore(), pick_init());
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_table_full();
    while (sems_created < NUM_SEMS) begin
      send_request(CMD_CREATE, 8'($urandom), 8'($urandom), pick_init());
    end
    repeat (2) send_request(CMD_CREATE, 8'($urandom), 8'($urandom), 32'($urandom));
    send_request(CMD_POST, 8'($urandom), 8'(NUM_SEMS - 1), 32'($urandom));
    send_request(CMD_TRY, 8'($urandom), 8'(NUM_SEMS - 1), 32'($urandom));
    send_request(CMD_WAIT, 8'($urandom), 8'(NUM_SEMS - 1), 32'($urandom));
  endtask

  initial begin : rsp_stall_gen
    int hold;
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rst));
    end
  end

  always @(posedge clk) begin : reply_checker
    reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request pending", dest_requester, -1);
      end else begin
        want = expected_replies.pop_front();
        if (dest_requester !== want.dest) report_mismatch("dest_requester", dest_requester, want.dest);
        if (reply_kind !== want.kind)     report_mismatch("reply_kind", reply_kind, want.kind);
        if (status !== want.code)         report_mismatch("status", status, want.code);
        if (result_index !== want.index)  report_mismatch("result_index", result_index, want.index);
        if (success !== want.granted)     report_mismatch("success", success, want.granted);
        if (last !== want.is_last)        report_mismatch("last", last, want.is_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unallocated_access();
    test_create_extremes();
    test_count_saturation();
    test_wait_queue();
    test_random_traffic();
    test_table_full();
    req_valid <= 1'b0;
    wait (expected_replies.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
